### hdl/acbh_pkg.sv
// Package: AES constants, S-box and shared types for the chained block hash.
`default_nettype none
package acbh_pkg;
   localparam int BlockBytes  = 16;
   localparam int DigestBytes = 20;
   localparam int Rounds      = 10;
   localparam int QueueDepth  = 2;

   localparam logic [0:0] CsrKeyHigh = 1'b0;
   localparam logic [0:0] CsrKeyLow  = 1'b1;

   // One queued block from front to back.
   typedef struct packed {
      logic [127:0] block;
      logic         first;
      logic         final_blk;
   } blk_job_type;

   typedef enum logic [1:0] {
      BK_IDLE, BK_ROUND, BK_EMIT
   } bk_state_type;

   function automatic logic [7:0] sbox(input logic [7:0] x);
      logic [7:0] t [0:255];
      t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
      return t[x];
   endfunction

   function automatic logic [7:0] xtime(input logic [7:0] x);
      return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
   endfunction

   // Byte i of a 128-bit word, byte 0 in the top bits.
   function automatic logic [7:0] get_b(input logic [127:0] w, input int i);
      return w[127-8*i -: 8];
   endfunction
endpackage
`default_nettype wire

### hdl/acbh_if.sv
// Valid/ready stream interfaces for requests and digest bytes.
`default_nettype none
interface acbh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last;
   modport source (output valid, data_byte, last, input ready);
   modport sink (input valid, data_byte, last, output ready);
endinterface

interface acbh_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] digest_byte;
   logic [4:0] byte_index;
   logic       final_byte;
   modport source (output valid, digest_byte, byte_index, final_byte, input ready);
   modport sink (input valid, digest_byte, byte_index, final_byte, output ready);
endinterface
`default_nettype wire

### hdl/aes128_chained_block_hash_unit.sv
// Top level of the chained AES-128 block hash.
// Flow: a completed block is registered in the front end, then enters the queue; the
// round unit runs one AES round per cycle; a final block then yields 20 digest bytes.
// Throughput: one byte per cycle unless stalled; one block at a time in the back end.
// Reset: synchronous, active high; clears fill count, chaining value, key and queue.
`default_nettype none
module aes128_chained_block_hash_unit import acbh_pkg::*; #(
   parameter int QDepth = QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   acbh_req_if.sink         req,
   acbh_rsp_if.source       rsp,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [63:0] csr_wdata
);
   logic [63:0] key_hi_ff, key_lo_ff;
   logic        f_valid, f_ready, b_valid, b_ready;
   blk_job_type f_job, b_job;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_hi_ff <= '0;
         key_lo_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CsrKeyHigh: key_hi_ff <= csr_wdata;
            CsrKeyLow:  key_lo_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   acbh_front u_front (.clock, .reset, .req, .job_valid(f_valid), .job(f_job),
      .job_ready(f_ready));
   acbh_queue #(.Depth(QDepth)) u_queue (.clock, .reset, .in_valid(f_valid), .in_job(f_job),
      .in_ready(f_ready), .out_valid(b_valid), .out_job(b_job), .out_ready(b_ready));
   acbh_back u_back (.clock, .reset, .key({key_hi_ff, key_lo_ff}), .job_valid(b_valid),
      .job(b_job), .job_ready(b_ready), .rsp);
endmodule
`default_nettype wire

### hdl/acbh_front.sv
// Front end: gathers request bytes into blocks, pads the last, feeds the block queue.
`default_nettype none
module acbh_front import acbh_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   acbh_req_if.sink         req,
   output      logic        job_valid,
   output      blk_job_type job,
   input  wire logic        job_ready
);
   logic [127:0] buf_ff, buf_in;
   logic [3:0]   fill_ff, fill_in;
   logic         first_ff, first_in;
   logic         vld_ff, vld_in;
   blk_job_type  job_ff, job_in;
   logic [127:0] blk;
   logic [7:0]   pad;
   logic         take;

   assign req.ready = !vld_ff || job_ready;
   assign take      = req.valid && req.ready;
   assign pad       = 8'(5'd16 - ({1'b0, fill_ff} + 5'd1));

   always_comb begin
      blk = buf_ff;
      for (int i = 0; i < BlockBytes; i++) begin
         if (i == int'(fill_ff)) blk[127-8*i -: 8] = req.data_byte;
         else if (i > int'(fill_ff) && req.last) blk[127-8*i -: 8] = pad;
      end
   end

   always_comb begin
      buf_in   = buf_ff;
      fill_in  = fill_ff;
      first_in = first_ff;
      vld_in   = vld_ff && !job_ready;
      job_in   = job_ff;
      if (take) begin
         buf_in  = blk;
         fill_in = fill_ff + 4'd1;
         if (req.last || fill_ff == 4'd15) begin
            vld_in   = 1'b1;
            job_in   = '{block: blk, first: first_ff, final_blk: req.last};
            fill_in  = '0;
            first_in = req.last;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         first_ff <= 1'b1;
         vld_ff   <= 1'b0;
      end else begin
         fill_ff  <= fill_in;
         first_ff <= first_in;
         vld_ff   <= vld_in;
      end
      buf_ff <= buf_in;
      job_ff <= job_in;
   end

   assign job_valid = vld_ff;
   assign job       = job_ff;
endmodule
`default_nettype wire

### hdl/acbh_queue.sv
// Short block queue between front and back.
`default_nettype none
module acbh_queue import acbh_pkg::*; #(
   parameter int Depth = QueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   input  wire blk_job_type in_job,
   output      logic        in_ready,
   output      logic        out_valid,
   output      blk_job_type out_job,
   input  wire logic        out_ready
);
   localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
   blk_job_type          mem_ff [Depth];
   logic [AW-1:0]        wp_ff, rp_ff;
   logic [$clog2(Depth+1)-1:0] cnt_ff;
   logic                 push, pop;

   assign in_ready  = cnt_ff != ($clog2(Depth+1))'(Depth);
   assign out_valid = cnt_ff != '0;
   assign out_job   = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= (wp_ff == AW'(Depth-1)) ? '0 : wp_ff + AW'(1);
         if (pop)  rp_ff <= (rp_ff == AW'(Depth-1)) ? '0 : rp_ff + AW'(1);
         cnt_ff <= cnt_ff + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
      end
      if (push) mem_ff[wp_ff] <= in_job;
   end
endmodule
`default_nettype wire

### hdl/acbh_back.sv
// Back end: one AES round per cycle, chaining, digest emission.
`default_nettype none
module acbh_back import acbh_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic [127:0] key,
   input  wire logic         job_valid,
   input  wire blk_job_type  job,
   output      logic         job_ready,
   acbh_rsp_if.source        rsp
);
   bk_state_type state_ff, state_in;
   logic [127:0] st_ff, st_in, rk_ff, rk_in, cv_ff, cv_in, pt_ff, pt_in;
   logic [3:0]   rnd_ff, rnd_in;
   logic [7:0]   rcon_ff, rcon_in;
   logic         fin_ff, fin_in;
   logic [4:0]   idx_ff, idx_in;
   logic [127:0] k0, sb, mc, nk, rstate;
   logic         start, last_rnd;
   logic [7:0]   t0, t1, t2, t3, xb;

   assign job_ready = state_ff == BK_IDLE;
   assign start     = job_valid && job_ready;
   assign k0        = job.first ? key : cv_ff;
   assign last_rnd  = rnd_ff == 4'(Rounds);

   always_comb begin
      for (int c = 0; c < 4; c++)
         for (int r = 0; r < 4; r++)
            sb[127-8*(c*4+r) -: 8] = sbox(get_b(st_ff, ((c + r) & 3) * 4 + r));
      for (int c = 0; c < 4; c++) begin
         t0 = get_b(sb, c*4); t1 = get_b(sb, c*4+1);
         t2 = get_b(sb, c*4+2); t3 = get_b(sb, c*4+3);
         xb = t0 ^ t1 ^ t2 ^ t3;
         mc[127-8*(c*4)   -: 8] = t0 ^ xb ^ xtime(t0 ^ t1);
         mc[127-8*(c*4+1) -: 8] = t1 ^ xb ^ xtime(t1 ^ t2);
         mc[127-8*(c*4+2) -: 8] = t2 ^ xb ^ xtime(t2 ^ t3);
         mc[127-8*(c*4+3) -: 8] = t3 ^ xb ^ xtime(t3 ^ t0);
      end
      nk[127:96] = rk_ff[127:96] ^ {sbox(get_b(rk_ff,13)) ^ rcon_ff,
                   sbox(get_b(rk_ff,14)), sbox(get_b(rk_ff,15)), sbox(get_b(rk_ff,12))};
      nk[95:64]  = rk_ff[95:64] ^ nk[127:96];
      nk[63:32]  = rk_ff[63:32] ^ nk[95:64];
      nk[31:0]   = rk_ff[31:0]  ^ nk[63:32];
      rstate     = (last_rnd ? sb : mc) ^ nk;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:  if (start) state_in = BK_ROUND;
         BK_ROUND: if (last_rnd) state_in = fin_ff ? BK_EMIT : BK_IDLE;
         BK_EMIT:  if (rsp.ready && idx_ff == 5'(DigestBytes-1)) state_in = BK_IDLE;
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      st_in = st_ff; rk_in = rk_ff; cv_in = cv_ff; pt_in = pt_ff;
      rnd_in = rnd_ff; rcon_in = rcon_ff; fin_in = fin_ff; idx_in = idx_ff;
      case (state_ff)
         BK_IDLE: if (start) begin
            st_in = job.block ^ k0; rk_in = k0; pt_in = job.block;
            rnd_in = 4'd1; rcon_in = 8'h01; fin_in = job.final_blk; idx_in = '0;
         end
         BK_ROUND: begin
            st_in = rstate; rk_in = nk;
            rnd_in = rnd_ff + 4'd1; rcon_in = xtime(rcon_ff);
            if (last_rnd) cv_in = rstate ^ pt_ff;
         end
         BK_EMIT: if (rsp.ready) begin
            idx_in = idx_ff + 5'd1;
            if (idx_ff == 5'(DigestBytes-1)) cv_in = '0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         cv_ff    <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cv_ff    <= cv_in;
         idx_ff   <= idx_in;
      end
      st_ff <= st_in; rk_ff <= rk_in; pt_ff <= pt_in;
      rnd_ff <= rnd_in; rcon_ff <= rcon_in; fin_ff <= fin_in;
   end

   always_comb begin
      if (idx_ff < 5'(BlockBytes))
         rsp.digest_byte = cv_ff[127 - 8*idx_ff[3:0] -: 8];
      else
         rsp.digest_byte = cv_ff[127 - 8*idx_ff[1:0] -: 8] ^ cv_ff[95 - 8*idx_ff[1:0] -: 8]
                         ^ cv_ff[63 - 8*idx_ff[1:0] -: 8] ^ cv_ff[31 - 8*idx_ff[1:0] -: 8];
   end
   assign rsp.valid      = state_ff == BK_EMIT;
   assign rsp.byte_index = idx_ff;
   assign rsp.final_byte = idx_ff == 5'(DigestBytes-1);

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> idx_ff < 5'(DigestBytes)) else $error("digest index out of range");
   a_rnd_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_ROUND |-> rnd_ff >= 4'd1 && rnd_ff <= 4'(Rounds))
      else $error("round counter out of range");
   a_cv_clear: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && rsp.final_byte |=> cv_ff == '0)
      else $error("chaining value not cleared");
endmodule
`default_nettype wire
